>>> rtl/ibd_pkg.sv
// Shared types, widths, codes and arithmetic helpers for the isolator deformation block.
`timescale 1ns / 1ps

package ibd_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SD_FRAC    = 16;
  localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

  localparam int DIMS    = 3;
  localparam int LANES   = 10;
  localparam int NUM_DEF = 6;

  localparam int XW      = FRAC_BITS + 2;
  localparam int BASIS_W = 34;
  localparam int VEC_W   = 33;
  localparam int PROD_W  = BASIS_W + VEC_W;
  localparam int LSUM_W  = PROD_W + 2;
  localparam int PROJ_W  = 53;
  localparam int SPLIT   = 26;
  localparam int PLO_W   = 32 + SPLIT;
  localparam int PHI_W   = 33 + PROJ_W - SPLIT;
  localparam int WIDE_W  = 90;
  localparam int DOT_W   = 52;
  localparam int CNT_W   = 5;

  localparam logic [16:0] SD_ONE = 17'd65536;
  localparam logic [DOT_W-1:0] PERP_TOL =
    DOT_W'(((64'd1 << (2 * FRAC_BITS)) + 64'd5000) / 64'd10000);

  localparam logic signed [31:0] AXIS_DX_RST  = 32'sd65536;
  localparam logic signed [31:0] AXIS_DY_RST  = 32'sd0;
  localparam logic signed [31:0] AXIS_DZ_RST  = 32'sd0;
  localparam logic signed [31:0] YREF_X_RST   = 32'sd0;
  localparam logic signed [31:0] YREF_Y_RST   = 32'sd65536;
  localparam logic signed [31:0] YREF_Z_RST   = 32'sd0;
  localparam logic [16:0]        SHEAR_RST    = 17'd32768;

  // Lanes: basis vector dotted with one triple of the word.
  localparam int LN_X_DT = 0;
  localparam int LN_X_DR = 1;
  localparam int LN_Y_DT = 2;
  localparam int LN_Y_DR = 3;
  localparam int LN_Z_DT = 4;
  localparam int LN_Z_DR = 5;
  localparam int LN_Y_R0 = 6;
  localparam int LN_Y_R1 = 7;
  localparam int LN_Z_R0 = 8;
  localparam int LN_Z_R1 = 9;

  localparam int DF_AXIAL   = 0;
  localparam int DF_SHEAR_Y = 1;
  localparam int DF_SHEAR_Z = 2;
  localparam int DF_TORSION = 3;
  localparam int DF_BEND_Y  = 4;
  localparam int DF_BEND_Z  = 5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_LEN = 2'd1,
    ST_NOT_PERP = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_AXIS_DX     = 3'd0,
    REG_AXIS_DY     = 3'd1,
    REG_AXIS_DZ     = 3'd2,
    REG_YREF_X      = 3'd3,
    REG_YREF_Y      = 3'd4,
    REG_YREF_Z      = 3'd5,
    REG_SHEAR_RATIO = 3'd6
  } reg_idx_e;

  typedef logic signed [BASIS_W-1:0] basis_t;
  typedef logic signed [VEC_W-1:0]   vec_t;
  typedef logic signed [LSUM_W-1:0]  lsum_t;
  typedef logic signed [PROJ_W-1:0]  proj_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic signed [31:0]        q_t;
  typedef basis_t [DIMS-1:0]         bvec_t;
  typedef vec_t [DIMS-1:0]           vvec_t;

  typedef struct packed {
    logic        busy;
    status_e     status;
    logic [31:0] arm_a;
    logic [31:0] arm_b;
    bvec_t       x;
    bvec_t       y;
    bvec_t       z;
  } geo_t;

  typedef struct packed {
    logic e_rnd;
    logic e_mul;
    logic e_sum;
    logic e_out;
  } mrg_en_t;

  localparam wide_t Q_MAX = wide_t'(64'sd2147483647);
  localparam wide_t Q_MIN = -Q_MAX - wide_t'(1);

  // Arithmetic right shift by the fraction width, rounding half up.
  function automatic wide_t round_shr(input wide_t v);
    return (v + wide_t'(ROUND_HALF)) >>> FRAC_BITS;
  endfunction

  function automatic q_t sat_q(input wide_t v);
    q_t r;
    if (v > Q_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < Q_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/ibd_lane.sv
// One projection lane: a basis vector dotted with a triple, over two register stages.
`timescale 1ns / 1ps

module ibd_lane import ibd_pkg::*; (
  input  logic  clk_i,
  input  logic  en_prod_i,
  input  logic  en_sum_i,
  input  bvec_t basis_i,
  input  vvec_t vec_i,
  output lsum_t sum_o
);

  logic signed [PROD_W-1:0] prod_d [DIMS];
  logic signed [PROD_W-1:0] prod_q [DIMS];
  lsum_t                    sum_q;

  always_comb begin
    for (int i = 0; i < DIMS; i++) begin
      prod_d[i] = basis_i[i] * vec_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_prod_i) begin
      prod_q <= prod_d;
    end
    if (en_sum_i) begin
      sum_q <= LSUM_W'(prod_q[0]) + LSUM_W'(prod_q[1]) + LSUM_W'(prod_q[2]);
    end
  end

  assign sum_o = sum_q;

endmodule

>>> rtl/ibd_geometry.sv
// Configuration registers and the sequencer that derives the local frame and shear arms.
`timescale 1ns / 1ps

module ibd_geometry import ibd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output geo_t        geo_o
);

  typedef enum logic [2:0] {
    G_SQ,
    G_SQRT,
    G_DIV,
    G_PROD,
    G_IDLE
  } geo_state_e;

  geo_state_e state_q;
  logic [CNT_W-1:0] cnt_q;

  logic signed [31:0] axis_q [DIMS];
  logic signed [31:0] yref_q [DIMS];
  logic [16:0]        shear_q;

  logic [63:0] sq_q;
  logic [63:0] rad_q;
  logic [63:0] root_q;
  logic [31:0] len_q;
  logic [32:0] rem_q [DIMS];
  logic [FRAC_BITS:0] quot_q [DIMS];
  logic signed [XW-1:0] x_q [DIMS];
  basis_t z_q [DIMS];
  logic signed [DOT_W-1:0] dot_q;
  logic [31:0] arm_a_q;
  logic [31:0] arm_b_q;
  status_e status_q;

  logic [31:0] axis_mag [DIMS];
  logic [63:0] sq_prod;
  logic [63:0] sq_sum;
  logic [63:0] bit_w;
  logic [63:0] trial;
  logic        take;
  logic [63:0] root_n;
  logic [63:0] rad_n;
  logic [33:0] div_d;
  logic [33:0] rs [DIMS];
  logic        ge [DIMS];
  logic [32:0] rem_n [DIMS];
  logic [FRAC_BITS:0] quot_n [DIMS];
  logic signed [XW-1:0] x_n [DIMS];
  logic [1:0] k;
  logic [1:0] j;
  logic [1:0] m;
  logic signed [XW+31:0] p1;
  logic signed [XW+31:0] p2;
  logic signed [XW+32:0] zdiff;
  logic signed [XW+33:0] zrnd;
  logic signed [XW+31:0] dotp;
  logic signed [DOT_W-1:0] dot_base;
  logic signed [DOT_W-1:0] dot_sum;
  logic [DOT_W-1:0] dot_abs;
  logic [16:0] sd;
  logic [48:0] arm_prod;
  logic [31:0] arm_a;

  always_comb begin
    for (int i = 0; i < DIMS; i++) begin
      axis_mag[i] = axis_q[i][31] ? 32'(-axis_q[i]) : axis_q[i];
    end
    k = cnt_q[1:0];
    sq_prod = axis_mag[k] * axis_mag[k];
    sq_sum  = sq_q + sq_prod;

    bit_w  = 64'd1 << {cnt_q, 1'b0};
    trial  = root_q + bit_w;
    take   = rad_q >= trial;
    root_n = take ? (root_q >> 1) + bit_w : root_q >> 1;
    rad_n  = take ? rad_q - trial : rad_q;

    div_d = {1'b0, len_q, 1'b0};
    for (int i = 0; i < DIMS; i++) begin
      rs[i]     = {rem_q[i], len_q[cnt_q]};
      ge[i]     = rs[i] >= div_d;
      rem_n[i]  = ge[i] ? 33'(rs[i] - div_d) : rs[i][32:0];
      quot_n[i] = {quot_q[i][FRAC_BITS-1:0], ge[i]};
      x_n[i]    = axis_q[i][31] ? -$signed({1'b0, quot_n[i]}) : $signed({1'b0, quot_n[i]});
    end

    case (k)
      2'd0: begin
        j = 2'd1;
        m = 2'd2;
      end
      2'd1: begin
        j = 2'd2;
        m = 2'd0;
      end
      2'd2: begin
        j = 2'd0;
        m = 2'd1;
      end
      default: begin
        j = 2'd1;
        m = 2'd2;
      end
    endcase
    p1       = x_q[j] * yref_q[m];
    p2       = x_q[m] * yref_q[j];
    zdiff    = (XW + 33)'(p1) - (XW + 33)'(p2);
    zrnd     = ((XW + 34)'(zdiff) + (XW + 34)'(ROUND_HALF)) >>> FRAC_BITS;
    dotp     = x_q[k] * yref_q[k];
    dot_base = (k == 2'd0) ? '0 : dot_q;
    dot_sum  = dot_base + DOT_W'(dotp);
    dot_abs  = dot_sum[DOT_W-1] ? DOT_W'(-dot_sum) : dot_sum;

    sd       = (shear_q > SD_ONE) ? SD_ONE : shear_q;
    arm_prod = sd * len_q;
    arm_a    = 32'((arm_prod + 49'd32768) >> SD_FRAC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= G_SQ;
      cnt_q    <= '0;
      sq_q     <= '0;
      status_q <= ST_OK;
      axis_q[0] <= AXIS_DX_RST;
      axis_q[1] <= AXIS_DY_RST;
      axis_q[2] <= AXIS_DZ_RST;
      yref_q[0] <= YREF_X_RST;
      yref_q[1] <= YREF_Y_RST;
      yref_q[2] <= YREF_Z_RST;
      shear_q   <= SHEAR_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_AXIS_DX:     axis_q[0] <= cfg_wdata_i;
        REG_AXIS_DY:     axis_q[1] <= cfg_wdata_i;
        REG_AXIS_DZ:     axis_q[2] <= cfg_wdata_i;
        REG_YREF_X:      yref_q[0] <= cfg_wdata_i;
        REG_YREF_Y:      yref_q[1] <= cfg_wdata_i;
        REG_YREF_Z:      yref_q[2] <= cfg_wdata_i;
        REG_SHEAR_RATIO: shear_q   <= cfg_wdata_i[16:0];
        default: ;
      endcase
      state_q <= G_SQ;
      cnt_q   <= '0;
      sq_q    <= '0;
    end else begin
      case (state_q)
        G_SQ: begin
          sq_q <= sq_sum;
          if (cnt_q == CNT_W'(DIMS - 1)) begin
            if (sq_sum == 64'd0) begin
              status_q <= ST_ZERO_LEN;
              state_q  <= G_IDLE;
            end else begin
              rad_q   <= sq_sum;
              root_q  <= '0;
              cnt_q   <= '1;
              state_q <= G_SQRT;
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        G_SQRT: begin
          rad_q  <= rad_n;
          root_q <= root_n;
          if (cnt_q == '0) begin
            len_q <= root_n[31:0];
            for (int i = 0; i < DIMS; i++) begin
              rem_q[i] <= 33'(axis_mag[i]) + 33'(root_n[31:FRAC_BITS+1]);
            end
            cnt_q   <= CNT_W'(FRAC_BITS);
            state_q <= G_DIV;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        G_DIV: begin
          rem_q  <= rem_n;
          quot_q <= quot_n;
          if (cnt_q == '0) begin
            x_q     <= x_n;
            state_q <= G_PROD;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        G_PROD: begin
          z_q[k] <= BASIS_W'(zrnd);
          dot_q  <= dot_sum;
          if (k == 2'd0) begin
            arm_a_q <= arm_a;
          end
          if (cnt_q == CNT_W'(DIMS - 1)) begin
            status_q <= (dot_abs > PERP_TOL) ? ST_NOT_PERP : ST_OK;
            arm_b_q  <= len_q - arm_a_q;
            state_q  <= G_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        G_IDLE: ;
        default: state_q <= G_IDLE;
      endcase
    end
  end

  always_comb begin
    geo_o.busy   = state_q != G_IDLE;
    geo_o.status = status_q;
    geo_o.arm_a  = arm_a_q;
    geo_o.arm_b  = arm_b_q;
    for (int i = 0; i < DIMS; i++) begin
      geo_o.x[i] = BASIS_W'(x_q[i]);
      geo_o.y[i] = BASIS_W'(yref_q[i]);
      geo_o.z[i] = z_q[i];
    end
  end

endmodule

>>> rtl/ibd_merge.sv
// Merging stages: end-rotation shear correction, rounding, saturation and status masking.
`timescale 1ns / 1ps

module ibd_merge import ibd_pkg::*; (
  input  logic                 clk_i,
  input  mrg_en_t              en_i,
  input  geo_t                 geo_i,
  input  lsum_t [LANES-1:0]    lane_sum_i,
  output q_t [NUM_DEF-1:0]     def_o,
  output status_e              status_o
);

  localparam int NPASS = 6;
  localparam int NTERM = 4;

  lsum_t pa_q [NPASS];
  lsum_t pb_q [NPASS];
  lsum_t pc_q [NPASS];
  proj_t lp_q [NTERM];
  proj_t lp_d [NTERM];
  logic [PLO_W-1:0]        plo_d [NTERM];
  logic [PLO_W-1:0]        plo_q [NTERM];
  logic signed [PHI_W-1:0] phi_d [NTERM];
  logic signed [PHI_W-1:0] phi_q [NTERM];
  logic [31:0] arm [NTERM];
  wide_t term [NTERM];
  wide_t shy_d;
  wide_t shz_d;
  wide_t shy_q;
  wide_t shz_q;
  q_t    def_d [NUM_DEF];
  q_t    def_q [NUM_DEF];
  status_e status_q;

  always_comb begin
    lp_d[0] = PROJ_W'(round_shr(WIDE_W'(lane_sum_i[LN_Z_R0])));
    lp_d[1] = PROJ_W'(round_shr(WIDE_W'(lane_sum_i[LN_Z_R1])));
    lp_d[2] = PROJ_W'(round_shr(WIDE_W'(lane_sum_i[LN_Y_R0])));
    lp_d[3] = PROJ_W'(round_shr(WIDE_W'(lane_sum_i[LN_Y_R1])));

    for (int t = 0; t < NTERM; t++) begin
      arm[t]   = t[0] ? geo_i.arm_b : geo_i.arm_a;
      plo_d[t] = arm[t] * lp_q[t][SPLIT-1:0];
      phi_d[t] = $signed({1'b0, arm[t]}) * $signed(lp_q[t][PROJ_W-1:SPLIT]);
      term[t]  = (WIDE_W'(phi_q[t]) <<< SPLIT) + $signed(WIDE_W'(plo_q[t]));
    end
    shy_d = WIDE_W'(pb_q[LN_Y_DT]) - term[0] - term[1];
    shz_d = WIDE_W'(pb_q[LN_Z_DT]) + term[2] + term[3];

    def_d[DF_AXIAL]   = sat_q(round_shr(WIDE_W'(pc_q[LN_X_DT])));
    def_d[DF_SHEAR_Y] = sat_q(round_shr(shy_q));
    def_d[DF_SHEAR_Z] = sat_q(round_shr(shz_q));
    def_d[DF_TORSION] = sat_q(round_shr(WIDE_W'(pc_q[LN_X_DR])));
    def_d[DF_BEND_Y]  = sat_q(round_shr(WIDE_W'(pc_q[LN_Y_DR])));
    def_d[DF_BEND_Z]  = sat_q(round_shr(WIDE_W'(pc_q[LN_Z_DR])));
  end

  always_ff @(posedge clk_i) begin
    if (en_i.e_rnd) begin
      for (int i = 0; i < NPASS; i++) begin
        pa_q[i] <= lane_sum_i[i];
      end
      lp_q <= lp_d;
    end
    if (en_i.e_mul) begin
      pb_q  <= pa_q;
      plo_q <= plo_d;
      phi_q <= phi_d;
    end
    if (en_i.e_sum) begin
      pc_q  <= pb_q;
      shy_q <= shy_d;
      shz_q <= shz_d;
    end
    if (en_i.e_out) begin
      status_q <= geo_i.status;
      for (int i = 0; i < NUM_DEF; i++) begin
        def_q[i] <= (geo_i.status == ST_OK) ? def_d[i] : '0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_DEF; i++) begin
      def_o[i] = def_q[i];
    end
  end

  assign status_o = status_q;

endmodule

>>> rtl/isolator_basic_deformation.sv
// Top level: input register, ten projection lanes, merging stages and pipeline control.
//
//   channel  direction  handshake                  content
//   cfg      in         cfg_we_i                   cfg_idx_i, cfg_wdata_i
//   in       in         in_valid_i / in_stall_o    twelve nodal components
//   out      out        out_valid_o / out_stall_i  six basic deformations and status
//
// One word is accepted per cycle while in_stall_o is low; results appear seven register
// stages after acceptance. After reset and after every configuration write the frame
// sequencer runs three squaring, 32 square-root, 17 division and three product steps,
// or the squaring steps alone for a zero-length axis, and stalls the input meanwhile.
// Each pipeline stage advances whenever the stage after it is empty or moving, so words
// keep entering while a finished result waits on out_stall_i until the pipeline is full.
`timescale 1ns / 1ps

module isolator_basic_deformation import ibd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] n0_trans_x_i,
  input  logic signed [31:0] n0_trans_y_i,
  input  logic signed [31:0] n0_trans_z_i,
  input  logic signed [31:0] n0_rot_x_i,
  input  logic signed [31:0] n0_rot_y_i,
  input  logic signed [31:0] n0_rot_z_i,
  input  logic signed [31:0] n1_trans_x_i,
  input  logic signed [31:0] n1_trans_y_i,
  input  logic signed [31:0] n1_trans_z_i,
  input  logic signed [31:0] n1_rot_x_i,
  input  logic signed [31:0] n1_rot_y_i,
  input  logic signed [31:0] n1_rot_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] axial_def_o,
  output logic signed [31:0] shear_y_def_o,
  output logic signed [31:0] shear_z_def_o,
  output logic signed [31:0] torsion_def_o,
  output logic signed [31:0] bend_y_def_o,
  output logic signed [31:0] bend_z_def_o,
  output logic [1:0]         status_o
);

  localparam int NSTAGE = 7;

  geo_t geo;
  logic [NSTAGE-1:0] v_q;
  logic [NSTAGE-1:0] ready;
  logic accept;

  logic signed [31:0] t0_q [DIMS];
  logic signed [31:0] r0_q [DIMS];
  logic signed [31:0] t1_q [DIMS];
  logic signed [31:0] r1_q [DIMS];

  vvec_t dt_v;
  vvec_t dr_v;
  vvec_t r0_v;
  vvec_t r1_v;
  bvec_t lane_b [LANES];
  vvec_t lane_v [LANES];
  lsum_t [LANES-1:0] lane_sum;
  mrg_en_t mrg_en;
  q_t [NUM_DEF-1:0] def;
  status_e status;

  ibd_geometry u_geometry (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .geo_o       (geo)
  );

  always_comb begin
    ready[NSTAGE-1] = !v_q[NSTAGE-1] || !out_stall_i;
    for (int s = NSTAGE - 2; s >= 0; s--) begin
      ready[s] = !v_q[s] || ready[s+1];
    end
  end

  assign in_stall_o = geo.busy || !ready[0];
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ready[0]) begin
        v_q[0] <= accept;
      end
      for (int s = 1; s < NSTAGE; s++) begin
        if (ready[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      t0_q[0] <= n0_trans_x_i;
      t0_q[1] <= n0_trans_y_i;
      t0_q[2] <= n0_trans_z_i;
      r0_q[0] <= n0_rot_x_i;
      r0_q[1] <= n0_rot_y_i;
      r0_q[2] <= n0_rot_z_i;
      t1_q[0] <= n1_trans_x_i;
      t1_q[1] <= n1_trans_y_i;
      t1_q[2] <= n1_trans_z_i;
      r1_q[0] <= n1_rot_x_i;
      r1_q[1] <= n1_rot_y_i;
      r1_q[2] <= n1_rot_z_i;
    end
  end

  always_comb begin
    for (int i = 0; i < DIMS; i++) begin
      dt_v[i] = VEC_W'(t1_q[i]) - VEC_W'(t0_q[i]);
      dr_v[i] = VEC_W'(r1_q[i]) - VEC_W'(r0_q[i]);
      r0_v[i] = VEC_W'(r0_q[i]);
      r1_v[i] = VEC_W'(r1_q[i]);
    end
    lane_b[LN_X_DT] = geo.x;  lane_v[LN_X_DT] = dt_v;
    lane_b[LN_X_DR] = geo.x;  lane_v[LN_X_DR] = dr_v;
    lane_b[LN_Y_DT] = geo.y;  lane_v[LN_Y_DT] = dt_v;
    lane_b[LN_Y_DR] = geo.y;  lane_v[LN_Y_DR] = dr_v;
    lane_b[LN_Z_DT] = geo.z;  lane_v[LN_Z_DT] = dt_v;
    lane_b[LN_Z_DR] = geo.z;  lane_v[LN_Z_DR] = dr_v;
    lane_b[LN_Y_R0] = geo.y;  lane_v[LN_Y_R0] = r0_v;
    lane_b[LN_Y_R1] = geo.y;  lane_v[LN_Y_R1] = r1_v;
    lane_b[LN_Z_R0] = geo.z;  lane_v[LN_Z_R0] = r0_v;
    lane_b[LN_Z_R1] = geo.z;  lane_v[LN_Z_R1] = r1_v;
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    ibd_lane u_lane (
      .clk_i     (clk_i),
      .en_prod_i (ready[1]),
      .en_sum_i  (ready[2]),
      .basis_i   (lane_b[g]),
      .vec_i     (lane_v[g]),
      .sum_o     (lane_sum[g])
    );
  end

  assign mrg_en.e_rnd = ready[3];
  assign mrg_en.e_mul = ready[4];
  assign mrg_en.e_sum = ready[5];
  assign mrg_en.e_out = ready[6];

  ibd_merge u_merge (
    .clk_i      (clk_i),
    .en_i       (mrg_en),
    .geo_i      (geo),
    .lane_sum_i (lane_sum),
    .def_o      (def),
    .status_o   (status)
  );

  assign out_valid_o   = v_q[NSTAGE-1];
  assign axial_def_o   = def[DF_AXIAL];
  assign shear_y_def_o = def[DF_SHEAR_Y];
  assign shear_z_def_o = def[DF_SHEAR_Z];
  assign torsion_def_o = def[DF_TORSION];
  assign bend_y_def_o  = def[DF_BEND_Y];
  assign bend_z_def_o  = def[DF_BEND_Z];
  assign status_o      = status;

  // A result appears only when the stage before the output held a word.
  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(v_q[NSTAGE-2]))
    else $error("result appeared without a word in the last stage");

  // The frame sequencer starts only on a configuration write.
  a_busy_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(geo.busy) |-> $past(cfg_we_i))
    else $error("frame sequencer started without a write");

  // A settled frame stays settled until the next write.
  a_status_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !geo.busy && !cfg_we_i |=> $stable(geo.status) && $stable(geo.arm_b))
    else $error("frame changed without a write");

  // An error status forces all deformations to zero.
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |->
      axial_def_o == '0 && shear_y_def_o == '0 && shear_z_def_o == '0 &&
      torsion_def_o == '0 && bend_y_def_o == '0 && bend_z_def_o == '0)
    else $error("nonzero deformation with error status");

endmodule

>>> sim/tb.sv
// Self-checking testbench for the isolator basic deformation block.
`timescale 1ns / 1ps

import ibd_pkg::*;

typedef logic signed [127:0] big_t;

typedef struct packed {
  q_t [DIMS-1:0] t0;
  q_t [DIMS-1:0] r0;
  q_t [DIMS-1:0] t1;
  q_t [DIMS-1:0] r1;
} nodal_t;

typedef struct packed {
  q_t [NUM_DEF-1:0] def;
  status_e          status;
} deform_t;

localparam big_t PERP_LIMIT = ((64'd1 << (2 * FRAC_BITS)) + 64'd5000) / 64'd10000;

class deformation_scoreboard;
  q_t          axis [DIMS] = '{32'sd65536, 32'sd0, 32'sd0};
  q_t          yref [DIMS] = '{32'sd0, 32'sd65536, 32'sd0};
  logic [16:0] shear = 17'd32768;
  deform_t     due_deformations [$];
  int          errors = 0;
  int          checked = 0;
  string       field_name [NUM_DEF] = '{"axial_def", "shear_y_def", "shear_z_def",
                                        "torsion_def", "bend_y_def", "bend_z_def"};

  function void write_reg(logic [2:0] idx, logic [31:0] value);
    case (idx)
      REG_AXIS_DX: axis[0] = value;
      REG_AXIS_DY: axis[1] = value;
      REG_AXIS_DZ: axis[2] = value;
      REG_YREF_X: yref[0] = value;
      REG_YREF_Y: yref[1] = value;
      REG_YREF_Z: yref[2] = value;
      REG_SHEAR_RATIO: shear = value[16:0];
      default: ;
    endcase
  endfunction

  function big_t clamp(big_t v, int bits);
    big_t hi;
    big_t lo;
    hi = (big_t'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function big_t rshift_round(big_t v);
    return (v + (big_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function big_t to_q64(big_t v);
    return clamp(rshift_round(v), 64);
  endfunction

  function q_t settle(big_t v);
    big_t c;
    c = clamp(rshift_round(v), 32);
    return c[31:0];
  endfunction

  function big_t dot3(big_t p [DIMS], big_t q [DIMS]);
    big_t acc;
    acc = 0;
    for (int i = 0; i < DIMS; i++) acc += p[i] * q[i];
    return acc;
  endfunction

  function logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] probe;
    res = '0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v = v - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  function deform_t deform_of(nodal_t w);
    big_t d [DIMS], yv [DIMS], xv [DIMS], zv [DIMS];
    big_t t0 [DIMS], r0 [DIMS], t1 [DIMS], r1 [DIMS], dt [DIMS], dr [DIMS];
    big_t sq, len, q, mg, dmag, sd, arm_a, arm_b, lz0, lz1, ly0, ly1, s1, s2;
    deform_t res;
    res = '0;
    res.status = ST_OK;
    sq = 0;
    for (int i = 0; i < DIMS; i++) begin
      d[i] = axis[i];
      yv[i] = yref[i];
      sq += d[i] * d[i];
    end
    if (sq == 0) begin
      res.status = ST_ZERO_LEN;
    end else begin
      len = isqrt(sq[63:0]);
      for (int i = 0; i < DIMS; i++) begin
        mg = (d[i] < 0) ? -d[i] : d[i];
        q = ((mg <<< (FRAC_BITS + 1)) + len) / (2 * len);
        xv[i] = (d[i] < 0) ? -q : q;
      end
      dmag = clamp(dot3(xv, yv), 64);
      if (dmag < 0) dmag = -dmag;
      if (dmag > PERP_LIMIT) res.status = ST_NOT_PERP;
    end
    if (res.status == ST_OK) begin
      zv[0] = to_q64(xv[1] * yv[2] - xv[2] * yv[1]);
      zv[1] = to_q64(xv[2] * yv[0] - xv[0] * yv[2]);
      zv[2] = to_q64(xv[0] * yv[1] - xv[1] * yv[0]);
      sd = (shear > SD_ONE) ? SD_ONE : shear;
      arm_a = (sd * len + (big_t'(1) <<< (SD_FRAC - 1))) >>> SD_FRAC;
      arm_b = len - arm_a;
      for (int i = 0; i < DIMS; i++) begin
        t0[i] = $signed(w.t0[i]);
        r0[i] = $signed(w.r0[i]);
        t1[i] = $signed(w.t1[i]);
        r1[i] = $signed(w.r1[i]);
        dt[i] = t1[i] - t0[i];
        dr[i] = r1[i] - r0[i];
      end
      lz0 = to_q64(dot3(zv, r0));
      lz1 = to_q64(dot3(zv, r1));
      ly0 = to_q64(dot3(yv, r0));
      ly1 = to_q64(dot3(yv, r1));
      s1 = dot3(yv, dt) - arm_a * lz0 - arm_b * lz1;
      s2 = dot3(zv, dt) + arm_a * ly0 + arm_b * ly1;
      res.def[DF_AXIAL] = settle(dot3(xv, dt));
      res.def[DF_SHEAR_Y] = settle(s1);
      res.def[DF_SHEAR_Z] = settle(s2);
      res.def[DF_TORSION] = settle(dot3(xv, dr));
      res.def[DF_BEND_Y] = settle(dot3(yv, dr));
      res.def[DF_BEND_Z] = settle(dot3(zv, dr));
    end
    return res;
  endfunction

  function void note_word(nodal_t w);
    due_deformations = {due_deformations, deform_of(w)};
  endfunction

  function void check_result(deform_t got);
    deform_t want;
    checked++;
    if (due_deformations.size() == 0) begin
      $error("result word arrived with no expectation pending");
      errors++;
    end else begin
      want = due_deformations.pop_front();
      for (int i = 0; i < NUM_DEF; i++) begin
        if (got.def[i] !== want.def[i]) begin
          $error("%s: expected %0d, actual %0d", field_name[i],
                 $signed(want.def[i]), $signed(got.def[i]));
          errors++;
        end
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    end
  endfunction
endclass

module tb;
  localparam int         CYCLE_LIMIT = 400000;
  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam q_t         ONE = 32'sd65536;
  localparam q_t         Q_HI = 32'sh7fffffff;
  localparam q_t         Q_LO = 32'sh80000000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  nodal_t      word_in;
  logic        out_valid;
  logic        out_stall;
  q_t          axial, shear_y, shear_z, torsion, bend_y, bend_z;
  logic [1:0]  status;

  deformation_scoreboard sb;
  int idle_pct = 0;
  bit quiet = 1'b0;
  int hold_cycles = 0;
  int cycle_count = 0;
  int words_sent = 0;
  int settings_count = 0;

  isolator_basic_deformation dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .n0_trans_x_i (word_in.t0[0]),
    .n0_trans_y_i (word_in.t0[1]),
    .n0_trans_z_i (word_in.t0[2]),
    .n0_rot_x_i   (word_in.r0[0]),
    .n0_rot_y_i   (word_in.r0[1]),
    .n0_rot_z_i   (word_in.r0[2]),
    .n1_trans_x_i (word_in.t1[0]),
    .n1_trans_y_i (word_in.t1[1]),
    .n1_trans_z_i (word_in.t1[2]),
    .n1_rot_x_i   (word_in.r1[0]),
    .n1_rot_y_i   (word_in.r1[1]),
    .n1_rot_z_i   (word_in.r1[2]),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .axial_def_o  (axial),
    .shear_y_def_o(shear_y),
    .shear_z_def_o(shear_z),
    .torsion_def_o(torsion),
    .bend_y_def_o (bend_y),
    .bend_z_def_o (bend_z),
    .status_o     (status)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : watch
    deform_t seen;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("isolator_basic_deformation regression: fail");
      $finish;
    end else begin
      if (in_valid && !in_stall) begin
        sb.note_word(word_in);
        words_sent++;
      end
      if (out_valid && !out_stall) begin
        seen.def[DF_AXIAL] = axial;
        seen.def[DF_SHEAR_Y] = shear_y;
        seen.def[DF_SHEAR_Z] = shear_z;
        seen.def[DF_TORSION] = torsion;
        seen.def[DF_BEND_Y] = bend_y;
        seen.def[DF_BEND_Z] = bend_z;
        seen.status = status_e'(status);
        sb.check_result(seen);
      end
    end
  end

  initial begin : receiver
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic q_t rand_q();
    q_t v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = $urandom;
      3, 4, 5: v = int'($urandom_range(0, 32'h1fffff)) - 32'sh100000;
      6: begin
        case ($urandom_range(0, 3))
          0: v = Q_HI;
          1: v = Q_LO;
          2: v = '0;
          default: v = -32'sd1;
        endcase
      end
      default: v = int'($urandom_range(0, 8191)) - 4096;
    endcase
    return v;
  endfunction

  function automatic nodal_t rand_word();
    nodal_t w;
    for (int i = 0; i < DIMS; i++) begin
      w.t0[i] = rand_q();
      w.r0[i] = rand_q();
      w.t1[i] = rand_q();
      w.r1[i] = rand_q();
    end
    return w;
  endfunction

  function automatic nodal_t fill(q_t t0v, q_t r0v, q_t t1v, q_t r1v);
    nodal_t w;
    for (int i = 0; i < DIMS; i++) begin
      w.t0[i] = t0v;
      w.r0[i] = r0v;
      w.t1[i] = t1v;
      w.r1[i] = r1v;
    end
    return w;
  endfunction

  task automatic send_word(input nodal_t w);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    word_in <= w;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.due_deformations.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
  endtask

  task automatic load_setup(input q_t dx, input q_t dy, input q_t dz, input q_t yx,
                            input q_t yy, input q_t yz, input logic [31:0] ratio);
    wait_idle();
    cfg_write(REG_AXIS_DX, dx);
    cfg_write(REG_AXIS_DY, dy);
    cfg_write(REG_AXIS_DZ, dz);
    cfg_write(REG_YREF_X, yx);
    cfg_write(REG_YREF_Y, yy);
    cfg_write(REG_YREF_Z, yz);
    cfg_write(REG_SHEAR_RATIO, ratio);
    cfg_write(REG_SPARE, $urandom);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  // The reference y axis is the cross product of two small integer vectors, so it is
  // exactly perpendicular to the axis and small enough to stay within tolerance.
  task automatic random_setup();
    int p [DIMS];
    int q [DIMS];
    int c [DIMS];
    int sa;
    int sy;
    logic [31:0] ratio;
    do begin
      for (int i = 0; i < DIMS; i++) begin
        p[i] = int'($urandom_range(0, 16)) - 8;
        q[i] = int'($urandom_range(0, 16)) - 8;
      end
      c[0] = p[1] * q[2] - p[2] * q[1];
      c[1] = p[2] * q[0] - p[0] * q[2];
      c[2] = p[0] * q[1] - p[1] * q[0];
    end while (c[0] == 0 && c[1] == 0 && c[2] == 0);
    sa = $urandom_range(1, 1 << $urandom_range(4, 27));
    sy = $urandom_range(1, 1500);
    case ($urandom_range(0, 5))
      0: ratio = 32'd0;
      1: ratio = 32'd65536;
      2: ratio = $urandom_range(65537, 131071);
      default: ratio = $urandom_range(0, 65536);
    endcase
    load_setup(p[0] * sa, p[1] * sa, p[2] * sa, c[0] * sy, c[1] * sy, c[2] * sy, ratio);
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    word_in = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    idle_pct = 15;
    send_word(fill('0, '0, '0, '0));
    send_word(fill(Q_HI, Q_HI, Q_HI, Q_HI));
    send_word(fill(Q_LO, Q_LO, Q_LO, Q_LO));
    send_word(fill(32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa));
    send_word(fill('0, ONE, '0, '0));
    send_word(fill('0, '0, ONE, -ONE));
    send_word(fill(Q_LO, '0, Q_HI, '0));
    send_word(fill(-32'sd1, -32'sd1, -32'sd1, -32'sd1));

    load_setup('0, '0, '0, '0, ONE, '0, 32'd32768);
    send_word(fill(ONE, ONE, -ONE, ONE));
    send_word(rand_word());

    load_setup(ONE, '0, '0, 32'sd6, ONE, '0, 32'd32768);
    send_word(fill(ONE, -ONE, Q_HI, ONE));
    send_word(rand_word());

    load_setup(ONE, '0, '0, 32'sd7, ONE, '0, 32'd32768);
    send_word(fill(ONE, -ONE, Q_HI, ONE));
    send_word(rand_word());

    load_setup(Q_LO, '0, '0, '0, Q_HI, '0, 32'd0);
    send_word(fill(Q_HI, Q_HI, Q_LO, Q_LO));
    send_word(fill(Q_LO, Q_HI, Q_HI, Q_LO));
    send_word(rand_word());

    load_setup('0, '0, Q_HI, Q_LO, '0, '0, 32'd65536);
    send_word(fill(Q_HI, Q_LO, Q_LO, Q_HI));
    send_word(fill(ONE, ONE, ONE, ONE));
    send_word(rand_word());

    load_setup(ONE, ONE, '0, -ONE, ONE, '0, 32'hffffffff);
    send_word(fill(ONE, ONE, -ONE, -ONE));
    send_word(rand_word());

    for (int ph = 0; ph < 8; ph++) begin
      random_setup();
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
      if (ph == 7) quiet = 1'b1;
      if (ph == 2) begin
        @(posedge clk_i);
        hold_cycles = 150;
      end
      for (int k = 0; k < 50; k++) begin
        send_word(rand_word());
        if (ph == 4 && k == 25) wait_idle();
      end
    end

    wait_idle();
    repeat (10) @(negedge clk_i);
    $display("Checked %0d result words from %0d input words over %0d register settings.",
             sb.checked, words_sent, settings_count);
    $display("Covered zero length, skewed y axis, saturation, shear clamp and long stalls.");
    if (sb.errors == 0) begin
      $display("isolator_basic_deformation regression: pass");
    end else begin
      $display("isolator_basic_deformation regression: fail");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/ibd_pkg.sv
rtl/ibd_lane.sv
rtl/ibd_geometry.sv
rtl/ibd_merge.sv
rtl/isolator_basic_deformation.sv
sim/tb.sv
